// ===== src/hsfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, codes and helpers of the humidity sensor frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

	// CRC-8 of the sensor frames: polynomial 0x31, initial value 0xFF, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// result status codes
	localparam logic [1:0] STATUS_GOOD    = 2'd0;
	localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
	localparam logic [1:0] STATUS_BUSY    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SENSOR_KIND     = 2'd0;
	localparam logic [1:0] CFG_SELECT_HUMIDITY = 2'd1;
	localparam logic [1:0] CFG_GAIN            = 2'd2;
	localparam logic [1:0] CFG_VALUE_OFFSET    = 2'd3;

	localparam int CFG_DATA_W = 21;

	typedef struct packed {
		logic               sensor_kind;
		logic               select_humidity;
		logic signed [15:0] gain;
		logic signed [20:0] value_offset;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic run_mul;
		logic run_div;
		logic run_gain;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic final_byte;
		logic out_free;
	} dp_status_t;

	// one byte of the running CRC, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/hsfd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_ctrl
// Sequencer: takes frame bytes, then steps the end-of-frame arithmetic.
// ----------------------------------------------------------------------------
module hsfd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire hsfd_pkg::dp_status_t dp_status,
	output hsfd_pkg::cmd_t            cmd
);
	import hsfd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_GAIN = 5'b01000,
		ST_SUM  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.take_byte = in_valid;
				if (in_valid && dp_status.final_byte) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.run_mul = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.run_div = 1'b1;
				state_d     = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.run_gain = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				// hold until the output register is free
				if (dp_status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/hsfd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_datapath
// Frame byte store, running CRC, unit conversion, gain/offset and output register.
// ----------------------------------------------------------------------------
module hsfd_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hsfd_pkg::cfg_t       cfg,
	input  wire hsfd_pkg::cmd_t       cmd,
	output hsfd_pkg::dp_status_t      dp_status,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 frame_start,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic signed [14:0]        temperature_centi,
	output logic [13:0]               humidity_centi,
	output logic signed [23:0]        scaled_value
);
	import hsfd_pkg::*;

	// frame tracking
	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic       crc_fail_q;
	logic [7:0] bytes_q [7];
	logic [1:0] status_q;

	logic [2:0] pos_eff, pos_cur;
	logic [7:0] crc_cur;
	logic       fail_cur, crc_mismatch, is_final;

	always_comb begin
		pos_eff      = frame_start ? 3'd0 : pos_q;
		pos_cur      = (pos_eff == 3'd7) ? 3'd6 : pos_eff;
		crc_cur      = frame_start ? CRC_INIT : crc_q;
		fail_cur     = frame_start ? 1'b0 : crc_fail_q;
		crc_mismatch = (crc_cur != rx_byte);
		is_final     = cfg.sensor_kind ? (pos_cur == 3'd6) : (pos_cur >= 3'd5);
	end

	assign dp_status.final_byte = is_final;
	assign dp_status.out_free   = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			bytes_q[pos_cur] <= rx_byte;
			if (is_final) begin
				if (cfg.sensor_kind && bytes_q[0][7]) begin
					status_q <= STATUS_BUSY;
				end else if (fail_cur || crc_mismatch) begin
					status_q <= STATUS_CRC_ERR;
				end else begin
					status_q <= STATUS_GOOD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 3'd0;
			crc_q      <= CRC_INIT;
			crc_fail_q <= 1'b0;
		end else if (cmd.take_byte) begin
			if (is_final) begin
				pos_q      <= 3'd0;
				crc_q      <= CRC_INIT;
				crc_fail_q <= 1'b0;
			end else if (!cfg.sensor_kind && pos_cur == 3'd2) begin
				// word CRC byte: check, then restart for the next word
				pos_q      <= pos_cur + 3'd1;
				crc_q      <= CRC_INIT;
				crc_fail_q <= fail_cur | crc_mismatch;
			end else begin
				pos_q      <= pos_cur + 3'd1;
				crc_q      <= crc8_byte(crc_cur, rx_byte);
				crc_fail_q <= fail_cur;
			end
		end
	end

	// raw readings scaled by the full-scale span
	logic [19:0] t_raw, h_raw;
	logic [14:0] t_coef;
	logic [34:0] t_prod_q;
	logic [33:0] h_prod_q;

	always_comb begin
		if (cfg.sensor_kind) begin
			h_raw  = {bytes_q[1], bytes_q[2], bytes_q[3][7:4]};
			t_raw  = {bytes_q[3][3:0], bytes_q[4], bytes_q[5]};
			t_coef = 15'd20000;
		end else begin
			h_raw  = {4'd0, bytes_q[3], bytes_q[4]};
			t_raw  = {4'd0, bytes_q[0], bytes_q[1]};
			t_coef = 15'd17500;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_mul) begin
			t_prod_q <= {15'd0, t_raw} * {20'd0, t_coef};
			h_prod_q <= {14'd0, h_raw} * 34'd10000;
		end
	end

	// divide by 65535 (fold high half into low) or by 2^20, truncating
	logic [16:0] t_fold, h_fold;
	logic        t_ge, h_ge;
	logic [14:0] t_quo;
	logic        t_rem_nz;
	logic [13:0] h_quo;
	logic [12:0] t_base;
	logic [15:0] t_centi_d;
	logic signed [14:0] t_centi_q;
	logic [13:0] h_centi_q;

	always_comb begin
		t_fold = {2'd0, t_prod_q[30:16]} + {1'b0, t_prod_q[15:0]};
		h_fold = {3'd0, h_prod_q[29:16]} + {1'b0, h_prod_q[15:0]};
		t_ge   = (t_fold >= 17'd65535);
		h_ge   = (h_fold >= 17'd65535);
		if (cfg.sensor_kind) begin
			t_quo    = t_prod_q[34:20];
			t_rem_nz = (t_prod_q[19:0] != 20'd0);
			h_quo    = h_prod_q[33:20];
			t_base   = 13'd5000;
		end else begin
			t_quo    = t_prod_q[30:16] + {14'd0, t_ge};
			t_rem_nz = t_ge ? (t_fold != 17'd65535) : (t_fold != 17'd0);
			h_quo    = h_prod_q[29:16] + {13'd0, h_ge};
			t_base   = 13'd4500;
		end
		// truncate toward zero below the offset point
		t_centi_d = {1'b0, t_quo} - {3'd0, t_base}
			+ {15'd0, (t_quo < {2'd0, t_base}) && t_rem_nz};
	end

	always_ff @(posedge clk) begin
		if (cmd.run_div) begin
			t_centi_q <= t_centi_d[14:0];
			h_centi_q <= h_quo;
		end
	end

	// gain, offset and saturation
	logic signed [15:0] sel;
	logic signed [31:0] gain_prod_q;
	logic signed [23:0] gain_quo;
	logic        [25:0] sum;
	logic        [23:0] sat;

	always_comb begin
		sel      = cfg.select_humidity ? $signed({2'd0, h_centi_q})
			: $signed({t_centi_q[14], t_centi_q});
		gain_quo = $signed(gain_prod_q[31:8])
			+ $signed({23'd0, gain_prod_q[31] && (gain_prod_q[7:0] != 8'd0)});
		sum      = {{2{gain_quo[23]}}, gain_quo} + {{5{cfg.value_offset[20]}}, cfg.value_offset};
		if (!sum[25] && (sum[24:23] != 2'b00)) begin
			sat = 24'h7FFFFF;
		end else if (sum[25] && (sum[24:23] != 2'b11)) begin
			sat = 24'h800000;
		end else begin
			sat = sum[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_gain) begin
			gain_prod_q <= 32'(sel) * 32'(cfg.gain);
		end
	end

	// output register
	logic               out_valid_q;
	logic [1:0]         status_out_q;
	logic signed [14:0] t_out_q;
	logic [13:0]        h_out_q;
	logic signed [23:0] scaled_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_out_q <= status_q;
			if (status_q == STATUS_GOOD) begin
				t_out_q      <= t_centi_q;
				h_out_q      <= h_centi_q;
				scaled_out_q <= sat;
			end else begin
				t_out_q      <= '0;
				h_out_q      <= '0;
				scaled_out_q <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_out_q;
	assign temperature_centi = t_out_q;
	assign humidity_centi    = h_out_q;
	assign scaled_value      = scaled_out_q;

endmodule
`default_nettype wire

// ===== src/humidity_sensor_frame_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes CRC-protected temperature/humidity sensor response frames.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall, rx_byte, frame_start) carries one
//    response byte per transaction; frame_start marks byte 0 of a frame.
//  - sensor_kind 0: six-byte frame, two words each with its own CRC-8.
//    sensor_kind 1: seven-byte frame, status byte, 20-bit fields, one CRC.
//  - Ordinary bytes are taken one per cycle and cause no result.
//  - The final byte of a frame starts the end-of-frame steps (multiply,
//    divide, gain, offset/saturate), with in_stall high during them; the
//    result appears on out_valid when the last step loads the output
//    register.
//  - The output register holds a finished result while out_stall is high;
//    bytes of the next frame are still taken meanwhile, and only the end-of
//    -frame sequence waits for the register to empty.
//  - Status 2 (busy) wins over status 1 (CRC); on either, value fields are 0.
//  - Configuration is written through cfg_wr_en/cfg_index/cfg_data, only
//    while no frame is in flight.
//  - Reset: frame position and CRC restart, no result pending, gain 1.0
//    (256), offset 0, format 0, temperature selected.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [hsfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic                              frame_start,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             status,
	output logic signed [14:0]                     temperature_centi,
	output logic [13:0]                            humidity_centi,
	output logic signed [23:0]                     scaled_value
);
	import hsfd_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	dp_status_t dp_status;

	// configuration registers; writes to them must only happen while idle (the user's duty, not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_kind     <= 1'b0;
			cfg_q.select_humidity <= 1'b0;
			cfg_q.gain            <= 16'sd256;
			cfg_q.value_offset    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SENSOR_KIND:     cfg_q.sensor_kind     <= cfg_data[0];
				CFG_SELECT_HUMIDITY: cfg_q.select_humidity <= cfg_data[0];
				CFG_GAIN:            cfg_q.gain            <= cfg_data[15:0];
				CFG_VALUE_OFFSET:    cfg_q.value_offset    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: byte intake and end-of-frame steps
	hsfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// frame store, CRC, conversion and output register
	hsfd_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.cmd               (cmd),
		.dp_status         (dp_status),
		.rx_byte           (rx_byte),
		.frame_start       (frame_start),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.scaled_value      (scaled_value)
	);

endmodule
`default_nettype wire
